// ===== design/gnr_pkg.sv =====
// Shared types, constants and functions of the graphlet node role table expander.
// Holds the permutation table, the other-pair table and the controller command and status words.
// Depends on nothing; every other design file refers to it by scoped names.
package gnr_pkg;

	localparam int NUM_PERMS = 24;
	localparam int PERM_IDX_W = $clog2(NUM_PERMS);

	typedef logic [3:0][1:0] perm_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROLES,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic role_step;
		logic emit_step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic roles_done;
		logic emit_done;
	} ctrl_sts_t;

	// Node permutations in lexicographic order; entry x of a row is the source node of node x.
	localparam perm_t PERM_TAB [NUM_PERMS] = '{
		{2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0}, {2'd3, 2'd1, 2'd2, 2'd0},
		{2'd1, 2'd3, 2'd2, 2'd0}, {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
		{2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1}, {2'd3, 2'd0, 2'd2, 2'd1},
		{2'd0, 2'd3, 2'd2, 2'd1}, {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
		{2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2}, {2'd3, 2'd0, 2'd1, 2'd2},
		{2'd0, 2'd3, 2'd1, 2'd2}, {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
		{2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3}, {2'd2, 2'd0, 2'd1, 2'd3},
		{2'd0, 2'd2, 2'd1, 2'd3}, {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
	};

	// The two nodes other than a and b, indexed by {a, b}; the first node sits in the low bits.
	localparam logic [3:0] OTHER_PAIR [16] = '{
		{2'd0, 2'd0}, {2'd3, 2'd2}, {2'd3, 2'd1}, {2'd2, 2'd1},
		{2'd3, 2'd2}, {2'd0, 2'd0}, {2'd3, 2'd0}, {2'd2, 2'd0},
		{2'd3, 2'd1}, {2'd3, 2'd0}, {2'd0, 2'd0}, {2'd1, 2'd0},
		{2'd2, 2'd1}, {2'd2, 2'd0}, {2'd1, 2'd0}, {2'd0, 2'd0}
	};

	function automatic logic [15:0] apply_perm(input logic [15:0] code, input perm_t p);
		logic [15:0] r;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				r[i * 4 + j] = code[{p[i], p[j]}];
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] swap_nodes(input logic [15:0] code, input logic [1:0] a,
			input logic [1:0] b);
		perm_t p;
		p = {2'd3, 2'd2, 2'd1, 2'd0};
		p[a] = b;
		p[b] = a;
		return apply_perm(code, p);
	endfunction

endpackage

// ===== design/gnr_ctrl.sv =====
// Controller state machine of the graphlet node role table expander.
// Sequences the load, role search and table emission of the datapath; uses gnr_pkg.
module gnr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output gnr_pkg::ctrl_cmd_t  cmd,
	input  gnr_pkg::ctrl_sts_t  sts
);

	gnr_pkg::state_t state_q;
	gnr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gnr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			gnr_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = gnr_pkg::ST_ROLES;
				end
			end
			gnr_pkg::ST_ROLES: begin
				cmd.role_step = 1'b1;
				if (sts.roles_done) begin
					state_d = gnr_pkg::ST_EMIT;
				end
			end
			gnr_pkg::ST_EMIT: begin
				cmd.emit_step = 1'b1;
				if (sts.emit_done) begin
					state_d = gnr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gnr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/gnr_dp.sv =====
// Datapath of the graphlet node role table expander: work list, role registers,
// permutation mask and the registered result word. Uses gnr_pkg.
module gnr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         motif_code,
	input  gnr_pkg::ctrl_cmd_t  cmd,
	output gnr_pkg::ctrl_sts_t  sts,
	output logic                strobe,
	output logic [15:0]         entry_key,
	output logic [15:0]         canonical_code,
	output logic [2:0]          role_count,
	output logic [1:0]          role_node0,
	output logic [1:0]          role_node1,
	output logic [1:0]          role_node2,
	output logic [1:0]          role_node3,
	output logic                last_entry
);

	logic [15:0]                          code_q;
	logic [gnr_pkg::NUM_PERMS-1:0]        mask_q;
	logic [gnr_pkg::NUM_PERMS-1:0]        mask_d;
	gnr_pkg::perm_t                       list_q;
	gnr_pkg::perm_t                       roles_q;
	logic [2:0]                           len_q;
	logic [2:0]                           k_q;
	logic [1:0]                           keep_q;
	logic [2:0]                           count_q;
	logic [1:0]                           lead_q;
	logic [gnr_pkg::PERM_IDX_W-1:0]       ek_q;

	logic [1:0]                           lead;
	logic [1:0]                           cand;
	logic [3:0]                           other;
	logic [15:0]                          swap_a;
	logic [15:0]                          swap_b;
	logic                                 hit;
	logic                                 round_end;
	logic                                 no_later;
	gnr_pkg::perm_t                       perm;

	logic                                 strobe_q;
	logic                                 last_q;
	logic [15:0]                          key_q;
	gnr_pkg::perm_t                       out_roles_q;

	always_comb begin
		mask_d[0] = 1'b1;
		for (int p = 1; p < gnr_pkg::NUM_PERMS; p++) begin
			mask_d[p] = gnr_pkg::apply_perm(motif_code, gnr_pkg::PERM_TAB[p]) != motif_code;
		end
	end

	assign lead = lead_q;
	assign cand = list_q[k_q[1:0]];
	assign other = gnr_pkg::OTHER_PAIR[{lead, cand}];
	assign swap_a = gnr_pkg::swap_nodes(code_q, lead, cand);
	assign swap_b = gnr_pkg::swap_nodes(swap_a, other[1:0], other[3:2]);
	assign hit = (swap_a == code_q) || (swap_b == code_q);
	assign round_end = (k_q == len_q);

	assign perm = gnr_pkg::PERM_TAB[ek_q];

	always_comb begin
		no_later = 1'b1;
		for (int p = 0; p < gnr_pkg::NUM_PERMS; p++) begin
			if (p > int'(ek_q) && mask_q[p]) begin
				no_later = 1'b0;
			end
		end
	end

	assign sts.roles_done = round_end && (keep_q == 2'd0);
	assign sts.emit_done = mask_q[ek_q] && no_later;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= motif_code;
			mask_q <= mask_d;
			list_q <= {2'd3, 2'd2, 2'd1, 2'd0};
			roles_q <= '0;
			len_q <= 3'd4;
			k_q <= 3'd1;
			keep_q <= 2'd0;
			count_q <= 3'd0;
			lead_q <= 2'd0;
			ek_q <= '0;
		end else if (cmd.role_step) begin
			if (!round_end) begin
				if (hit) begin
					roles_q[cand] <= count_q[1:0];
				end else begin
					list_q[keep_q] <= cand;
					keep_q <= keep_q + 2'd1;
				end
				k_q <= k_q + 3'd1;
			end else begin
				len_q <= {1'b0, keep_q};
				count_q <= count_q + 3'd1;
				k_q <= 3'd1;
				keep_q <= 2'd0;
				lead_q <= list_q[0];
				if (keep_q != 2'd0) begin
					roles_q[list_q[0]] <= count_q[1:0] + 2'd1;
				end
			end
		end else if (cmd.emit_step) begin
			ek_q <= ek_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			key_q <= (ek_q == '0) ? code_q : gnr_pkg::apply_perm(code_q, perm);
			for (int x = 0; x < 4; x++) begin
				out_roles_q[x] <= roles_q[perm[x]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_step && mask_q[ek_q];
			last_q <= cmd.emit_step && mask_q[ek_q] && no_later;
		end
	end

	assign strobe = strobe_q;
	assign last_entry = last_q;
	assign entry_key = key_q;
	assign canonical_code = code_q;
	assign role_count = count_q;
	assign role_node0 = out_roles_q[0];
	assign role_node1 = out_roles_q[1];
	assign role_node2 = out_roles_q[2];
	assign role_node3 = out_roles_q[3];

endmodule

// ===== design/graphlet_node_role_table_expander.sv =====
// Top level of the graphlet node role table expander; joins gnr_ctrl and gnr_dp.
// Depends on gnr_pkg, gnr_ctrl and gnr_dp.
//
// A motif code word is taken when start is high and busy is low. The block then sorts the four
// nodes into roles, testing one candidate node per cycle against the leading node of the current
// role. It then steps through the node permutations in order at one per cycle, up to the last
// one that changes the code, and writes one table word for the code itself and one for every
// permutation that changes it. Each result word appears for
// exactly one cycle with strobe high and cannot be held off, so the receiver must take every word
// as it comes; last_entry marks the final word of an input, and busy falls in time for the next
// start to be taken in the cycle that word is shown.
module graphlet_node_role_table_expander (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] motif_code,
	output logic        strobe,
	output logic [15:0] entry_key,
	output logic [15:0] canonical_code,
	output logic [2:0]  role_count,
	output logic [1:0]  role_node0,
	output logic [1:0]  role_node1,
	output logic [1:0]  role_node2,
	output logic [1:0]  role_node3,
	output logic        last_entry
);

	gnr_pkg::ctrl_cmd_t cmd;
	gnr_pkg::ctrl_sts_t sts;

	gnr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	gnr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.motif_code     (motif_code),
		.cmd            (cmd),
		.sts            (sts),
		.strobe         (strobe),
		.entry_key      (entry_key),
		.canonical_code (canonical_code),
		.role_count     (role_count),
		.role_node0     (role_node0),
		.role_node1     (role_node1),
		.role_node2     (role_node2),
		.role_node3     (role_node3),
		.last_entry     (last_entry)
	);

`ifndef NO_ASSERTIONS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not make the block busy");

	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result word shown without work in progress");

	a_more_to_come: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_entry |-> busy)
		else $error("block went idle before its final result word");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_entry |=> !strobe)
		else $error("result word shown after the final word of an input");
`endif

endmodule
